/* design/aks_pkg.sv */
// ----------------------------------------------------------------------------
// Ascending key sorter package
// Shared sizes and the link record passed between neighboring sort cells.
// ----------------------------------------------------------------------------
`default_nettype none

package aks_pkg;

	// Number of cells in the chain, which is the capacity of one run.
	localparam int MAX_KEYS = 64;

	// Width of a stored key.
	localparam int KEY_BITS = 16;

	// What one cell shows to its neighbors.
	typedef struct packed {
		logic                valid;  // cell holds a key
		logic                ins;    // new key belongs at or before this cell
		logic [KEY_BITS-1:0] key;    // stored key
	} aks_link_t;

	// Chain-wide controls, one action per cycle.
	typedef struct packed {
		logic insert;  // place the broadcast key into the sorted chain
		logic shift;   // move every key one cell toward the head
	} aks_ctrl_t;

endpackage

`default_nettype wire

/* design/aks_cell.sv */
// ----------------------------------------------------------------------------
// Ascending key sorter cell
// One slot of the sorted chain: compares the broadcast key with its own,
// takes its left neighbor's or the new key on insert, its right's on shift.
// ----------------------------------------------------------------------------
`default_nettype none

module aks_cell (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire aks_pkg::aks_ctrl_t         ctrl,
	input  wire [aks_pkg::KEY_BITS-1:0]     new_key,
	input  wire aks_pkg::aks_link_t         prev_link,
	input  wire aks_pkg::aks_link_t         next_link,
	output aks_pkg::aks_link_t              link
);

	logic                          valid_q;
	logic [aks_pkg::KEY_BITS-1:0]  key_q;
	logic                          ins;

	// An empty cell always accepts; a full one when the new key is smaller.
	assign ins  = !valid_q || (new_key < key_q);
	assign link = '{valid: valid_q, ins: ins, key: key_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.shift) begin
			valid_q <= next_link.valid;
		end else if (ctrl.insert) begin
			valid_q <= valid_q | prev_link.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			key_q <= next_link.key;
		end else if (ctrl.insert) begin
			if (prev_link.ins) begin
				key_q <= prev_link.key;
			end else if (ins) begin
				key_q <= new_key;
			end
		end
	end

endmodule

`default_nettype wire

/* design/ascending_key_sorter.sv */
// ----------------------------------------------------------------------------
// Ascending key sorter
// Collects a run of keys into a sorted chain of cells and, after the key
// flagged last, drains them in ascending order with the largest flagged.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake            Payload
//   -------  -------------------  ---------------------------
//   input    in_valid / in_stall  key, last_in
//   output   out_valid/out_stall  sorted_key, last_out
//
// Each accepted key is placed in its sorted position, so keys may arrive
// back to back. After the item flagged last the input stalls while the
// run drains, one key per cycle from the head cell whenever out_stall is
// low, and the input opens in the cycle after the final key is taken.
// Reset empties every cell. Keys arriving while all cells are full are
// dropped, though a last flag on such an item still starts the drain.
// ----------------------------------------------------------------------------
`default_nettype none

module ascending_key_sorter (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             in_valid,
	output logic                            in_stall,
	input  wire [aks_pkg::KEY_BITS-1:0]     key,
	input  wire                             last_in,
	output logic                            out_valid,
	input  wire                             out_stall,
	output logic [aks_pkg::KEY_BITS-1:0]    sorted_key,
	output logic                            last_out
);

	localparam int N = aks_pkg::MAX_KEYS;

	aks_pkg::aks_link_t  link     [N];
	aks_pkg::aks_link_t  prev_link[N];
	aks_pkg::aks_link_t  next_link[N];
	aks_pkg::aks_ctrl_t  ctrl;

	logic draining_q;
	logic in_take;
	logic full;

	// The chain is full once its tail cell holds a key.
	assign full    = link[N-1].valid;
	assign in_stall = draining_q;
	assign in_take  = in_valid && !draining_q;

	// The head cell feeds the output; it is the smallest remaining key.
	assign out_valid  = draining_q && link[0].valid;
	assign sorted_key = link[0].key;
	assign last_out   = !link[1].valid;

	assign ctrl = '{insert: in_take && !full, shift: out_valid && !out_stall};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			draining_q <= 1'b0;
		end else if (in_take && last_in) begin
			draining_q <= 1'b1;
		end else if (ctrl.shift && last_out) begin
			draining_q <= 1'b0;
		end
	end

	// The head sees a full, non-inserting neighbor on its left so it never
	// copies from outside; the tail refills with an empty slot on a shift.
	for (genvar i = 0; i < N; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign prev_link[i] = '{valid: 1'b1, ins: 1'b0, key: '0};
		end else begin : g_body
			assign prev_link[i] = link[i-1];
		end
		if (i == N - 1) begin : g_tail
			assign next_link[i] = '{valid: 1'b0, ins: 1'b1, key: '0};
		end else begin : g_mid
			assign next_link[i] = link[i+1];
		end

		aks_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.new_key   (key),
			.prev_link (prev_link[i]),
			.next_link (next_link[i]),
			.link      (link[i])
		);
	end

endmodule

`default_nettype wire
